FILE: design/morse_character_pulse_encoder_core_macros.svh
// assertion macros for the morse pulse encoder checker
`ifndef MORSE_CHARACTER_PULSE_ENCODER_CORE_MACROS_SVH
`define MORSE_CHARACTER_PULSE_ENCODER_CORE_MACROS_SVH

// checked outside reset
`define MCPE_ASSERT(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) prop) else $error(msg);

// checked during reset too
`define MCPE_ASSERT_RST(lbl, prop, msg) \
   lbl: assert property (@(posedge clock) prop) else $error(msg);

`endif

FILE: design/mcpe_pkg.sv
// shared types, constants and code tables of the morse pulse encoder
package mcpe_pkg;

   localparam int CHAR_W = 8;
   localparam int UNIT_W = 20;
   localparam int DUR_W  = 23;
   localparam int LEN_W  = 3;
   localparam int PAT_W  = 5;

   localparam logic [UNIT_W-1:0] UNIT_RESET  = 20'd250000;
   localparam logic [CHAR_W-1:0] CASE_OFFSET = 8'd32;

   localparam logic [CHAR_W-1:0] ASCII_SPACE   = 8'h20;
   localparam logic [CHAR_W-1:0] ASCII_ZERO    = 8'h30;
   localparam logic [CHAR_W-1:0] ASCII_NINE    = 8'h39;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_A = 8'h41;
   localparam logic [CHAR_W-1:0] ASCII_UPPER_Z = 8'h5A;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_A = 8'h61;
   localparam logic [CHAR_W-1:0] ASCII_LOWER_Z = 8'h7A;

   localparam logic [LEN_W-1:0] DIGIT_LEN = 3'd5;

   // bit i set: element i is a dash
   localparam logic [PAT_W-1:0] DIGIT_PATTERN [10] = '{
      5'b11111, 5'b11110, 5'b11100, 5'b11000, 5'b10000,
      5'b00000, 5'b00001, 5'b00011, 5'b00111, 5'b01111
   };

   localparam logic [LEN_W-1:0] LETTER_LEN [26] = '{
      3'd2, 3'd4, 3'd4, 3'd3, 3'd1, 3'd4, 3'd3, 3'd4, 3'd2, 3'd4,
      3'd3, 3'd4, 3'd2, 3'd2, 3'd3, 3'd4, 3'd4, 3'd3, 3'd3, 3'd1,
      3'd3, 3'd4, 3'd3, 3'd4, 3'd4, 3'd4
   };

   localparam logic [PAT_W-1:0] LETTER_PATTERN [26] = '{
      5'b00010, 5'b00001, 5'b00101, 5'b00001, 5'b00000, 5'b00100,
      5'b00011, 5'b00000, 5'b00000, 5'b01110, 5'b00101, 5'b00010,
      5'b00011, 5'b00001, 5'b00111, 5'b00110, 5'b01011, 5'b00010,
      5'b00000, 5'b00001, 5'b00100, 5'b01000, 5'b00110, 5'b01001,
      5'b01101, 5'b00011
   };

   typedef struct packed {
      logic             valid;
      logic             is_space;
      logic [LEN_W-1:0] len;
      logic [PAT_W-1:0] pattern;
   } code_type;

   typedef struct packed {
      logic             is_space;
      logic             gap;
      logic [LEN_W-1:0] len;
      logic [PAT_W-1:0] pattern;
   } desc_type;

   function automatic logic [CHAR_W-1:0] fold_char(input logic [CHAR_W-1:0] c);
      logic [CHAR_W-1:0] r;
      r = c;
      if (c >= ASCII_LOWER_A && c <= ASCII_LOWER_Z) begin
         r = c - CASE_OFFSET;
      end
      return r;
   endfunction

   function automatic code_type char_lookup(input logic [CHAR_W-1:0] c);
      code_type          r;
      logic [CHAR_W-1:0] off;
      r   = '0;
      off = '0;
      if (c >= ASCII_ZERO && c <= ASCII_NINE) begin
         off       = c - ASCII_ZERO;
         r.valid   = 1'b1;
         r.len     = DIGIT_LEN;
         r.pattern = DIGIT_PATTERN[off[3:0]];
      end else if (c >= ASCII_UPPER_A && c <= ASCII_UPPER_Z) begin
         off       = c - ASCII_UPPER_A;
         r.valid   = 1'b1;
         r.len     = LETTER_LEN[off[4:0]];
         r.pattern = LETTER_PATTERN[off[4:0]];
      end else if (c == ASCII_SPACE) begin
         r.valid    = 1'b1;
         r.is_space = 1'b1;
      end
      return r;
   endfunction

endpackage

FILE: design/mcpe_channels.sv
// valid/ready channel interfaces of the morse pulse encoder
interface mcpe_req_if;
   logic                      valid;
   logic                      ready;
   logic [mcpe_pkg::CHAR_W-1:0] char_code;

   modport source (output valid, output char_code, input ready);
   modport sink   (input valid, input char_code, output ready);
endinterface

interface mcpe_rsp_if;
   logic                     valid;
   logic                     ready;
   logic                     led_on;
   logic [mcpe_pkg::DUR_W-1:0] duration_ticks;
   logic                     last;

   modport source (output valid, output led_on, output duration_ticks, output last,
                   input ready);
   modport sink   (input valid, input led_on, input duration_ticks, input last,
                   output ready);
endinterface

interface mcpe_csr_if;
   logic                      valid;
   logic                      ready;
   logic [mcpe_pkg::UNIT_W-1:0] unit_ticks;

   modport source (output valid, output unit_ticks, input ready);
   modport sink   (input valid, input unit_ticks, output ready);
endinterface

FILE: design/morse_character_pulse_encoder_core.sv
// top level of the morse character pulse encoder
// the first interval of a character passes the queue, sequencer and output registers to rsp_port
// throughput: one interval per cycle while rsp_port is ready, one to eleven intervals a character
// characters that are dropped are never queued and take no back end time
// a two-entry queue lets the front take characters while the back still sends intervals
// reset: synchronous, clears queue, sequencer, output valid, previous char; presets unit length
module morse_character_pulse_encoder_core (
   input  logic       clock,
   input  logic       reset,
   mcpe_req_if.sink   req_port,
   mcpe_rsp_if.source rsp_port,
   mcpe_csr_if.sink   csr_port
);

   logic [mcpe_pkg::UNIT_W-1:0] unit_ticks_ff;
   logic [mcpe_pkg::UNIT_W-1:0] unit_ticks_in;
   logic                        q_ready;
   logic                        q_push;
   mcpe_pkg::desc_type          q_data;
   logic                        q_valid;
   mcpe_pkg::desc_type          q_head;
   logic                        q_pop;

   assign csr_port.ready = 1'b1;

   always_comb begin
      unit_ticks_in = (csr_port.valid && csr_port.ready) ? csr_port.unit_ticks : unit_ticks_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         unit_ticks_ff <= mcpe_pkg::UNIT_RESET;
      end else begin
         unit_ticks_ff <= unit_ticks_in;
      end
   end

   mcpe_front u_front (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_port),
      .q_ready  (q_ready),
      .q_push   (q_push),
      .q_data   (q_data)
   );

   mcpe_queue u_queue (
      .clock     (clock),
      .reset     (reset),
      .push      (q_push),
      .push_data (q_data),
      .pop       (q_pop),
      .not_full  (q_ready),
      .not_empty (q_valid),
      .head      (q_head)
   );

   mcpe_back u_back (
      .clock      (clock),
      .reset      (reset),
      .unit_ticks (unit_ticks_ff),
      .q_valid    (q_valid),
      .q_head     (q_head),
      .q_pop      (q_pop),
      .rsp_port   (rsp_port)
   );

endmodule

FILE: design/mcpe_front.sv
// front end: accepts characters, folds case, looks up the code, tracks the previous character
module mcpe_front (
   input  logic               clock,
   input  logic               reset,
   mcpe_req_if.sink           req_port,
   input  logic               q_ready,
   output logic               q_push,
   output mcpe_pkg::desc_type q_data
);

   logic [mcpe_pkg::CHAR_W-1:0] prev_ff;
   logic [mcpe_pkg::CHAR_W-1:0] prev_in;
   logic [mcpe_pkg::CHAR_W-1:0] folded;
   mcpe_pkg::code_type          code;
   logic                        accept;

   assign req_port.ready = q_ready;

   always_comb begin
      folded           = mcpe_pkg::fold_char(req_port.char_code);
      code             = mcpe_pkg::char_lookup(folded);
      accept           = req_port.valid && q_ready;
      q_push           = accept && code.valid;
      q_data.is_space  = code.is_space;
      q_data.gap       = (folded != prev_ff);
      q_data.len       = code.len;
      q_data.pattern   = code.pattern;
      prev_in          = q_push ? folded : prev_ff;
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         prev_ff <= '0;
      end else begin
         prev_ff <= prev_in;
      end
   end

endmodule

FILE: design/mcpe_queue.sv
// two-entry descriptor queue between front and back
module mcpe_queue (
   input  logic               clock,
   input  logic               reset,
   input  logic               push,
   input  mcpe_pkg::desc_type push_data,
   input  logic               pop,
   output logic               not_full,
   output logic               not_empty,
   output mcpe_pkg::desc_type head
);

   mcpe_pkg::desc_type mem [2];
   logic               wr_ptr_ff;
   logic               wr_ptr_in;
   logic               rd_ptr_ff;
   logic               rd_ptr_in;
   logic [1:0]         count_ff;
   logic [1:0]         count_in;

   always_comb begin
      not_full  = (count_ff != 2'd2);
      not_empty = (count_ff != 2'd0);
      head      = mem[rd_ptr_ff];
      wr_ptr_in = push ? ~wr_ptr_ff : wr_ptr_ff;
      rd_ptr_in = pop ? ~rd_ptr_ff : rd_ptr_ff;
      count_in  = count_ff + {1'b0, push} - {1'b0, pop};
   end

   always_ff @(posedge clock) begin
      if (push) begin
         mem[wr_ptr_ff] <= push_data;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         wr_ptr_ff <= 1'b0;
         rd_ptr_ff <= 1'b0;
         count_ff  <= '0;
      end else begin
         wr_ptr_ff <= wr_ptr_in;
         rd_ptr_ff <= rd_ptr_in;
         count_ff  <= count_in;
      end
   end

endmodule

FILE: design/mcpe_back.sv
// back end: steps through the intervals of one character into the output register
module mcpe_back (
   input  logic                        clock,
   input  logic                        reset,
   input  logic [mcpe_pkg::UNIT_W-1:0] unit_ticks,
   input  logic                        q_valid,
   input  mcpe_pkg::desc_type          q_head,
   output logic                        q_pop,
   mcpe_rsp_if.source                  rsp_port
);

   typedef enum logic [3:0] {
      PH_ON    = 4'b0001,
      PH_OFF   = 4'b0010,
      PH_SPACE = 4'b0100,
      PH_GAP   = 4'b1000
   } phase_type;

   typedef enum logic [1:0] {
      UNITS_ONE   = 2'd0,
      UNITS_TWO   = 2'd1,
      UNITS_THREE = 2'd2,
      UNITS_SIX   = 2'd3
   } units_type;

   phase_type                    phase_ff;
   phase_type                    phase_in;
   phase_type                    phase_next;
   logic [mcpe_pkg::LEN_W-1:0]   idx_ff;
   logic [mcpe_pkg::LEN_W-1:0]   idx_in;
   logic [mcpe_pkg::LEN_W-1:0]   idx_next;
   logic                         busy_ff;
   logic                         busy_in;
   mcpe_pkg::desc_type           desc_ff;
   mcpe_pkg::desc_type           desc_in;
   logic                         valid_ff;
   logic                         valid_in;
   logic                         led_ff;
   logic                         led_in;
   logic [mcpe_pkg::DUR_W-1:0]   dur_ff;
   logic [mcpe_pkg::DUR_W-1:0]   dur_in;
   logic                         last_ff;
   logic                         last_in;
   units_type                    units;
   logic                         led;
   logic                         done;
   logic                         last_elem;
   logic                         advance;
   logic                         emit;
   logic [mcpe_pkg::DUR_W-1:0]   u1;
   logic [mcpe_pkg::DUR_W-1:0]   u2;
   logic [mcpe_pkg::DUR_W-1:0]   u3;

   assign rsp_port.valid          = valid_ff;
   assign rsp_port.led_on         = led_ff;
   assign rsp_port.duration_ticks = dur_ff;
   assign rsp_port.last           = last_ff;

   always_comb begin
      last_elem  = ((idx_ff + 3'd1) == desc_ff.len);
      units      = UNITS_ONE;
      led        = 1'b0;
      done       = 1'b0;
      phase_next = phase_ff;
      idx_next   = idx_ff;
      unique case (phase_ff)
         PH_ON: begin
            led        = 1'b1;
            units      = desc_ff.pattern[idx_ff] ? UNITS_THREE : UNITS_ONE;
            phase_next = PH_OFF;
         end
         PH_OFF: begin
            if (last_elem) begin
               if (desc_ff.gap) begin
                  phase_next = PH_GAP;
               end else begin
                  done = 1'b1;
               end
            end else begin
               idx_next   = idx_ff + 3'd1;
               phase_next = PH_ON;
            end
         end
         PH_SPACE: begin
            units = UNITS_SIX;
            if (desc_ff.gap) begin
               phase_next = PH_GAP;
            end else begin
               done = 1'b1;
            end
         end
         PH_GAP: begin
            units = UNITS_TWO;
            done  = 1'b1;
         end
         default: begin
            done = 1'b1;
         end
      endcase
   end

   always_comb begin
      u1 = {{(mcpe_pkg::DUR_W - mcpe_pkg::UNIT_W){1'b0}}, unit_ticks};
      u2 = u1 << 1;
      u3 = u1 + u2;
      unique case (units)
         UNITS_ONE:   dur_in = u1;
         UNITS_TWO:   dur_in = u2;
         UNITS_THREE: dur_in = u3;
         UNITS_SIX:   dur_in = u3 << 1;
         default:     dur_in = u1;
      endcase
   end

   always_comb begin
      advance  = !valid_ff || rsp_port.ready;
      emit     = busy_ff && advance;
      q_pop    = q_valid && (!busy_ff || (emit && done));
      led_in   = led;
      last_in  = done;
      valid_in = emit || (valid_ff && !rsp_port.ready);
      desc_in  = q_pop ? q_head : desc_ff;
      if (q_pop) begin
         busy_in  = 1'b1;
         idx_in   = '0;
         phase_in = q_head.is_space ? PH_SPACE : PH_ON;
      end else if (emit) begin
         busy_in  = !done;
         idx_in   = idx_next;
         phase_in = phase_next;
      end else begin
         busy_in  = busy_ff;
         idx_in   = idx_ff;
         phase_in = phase_ff;
      end
   end

   always_ff @(posedge clock) begin
      desc_ff <= desc_in;
      if (emit) begin
         led_ff  <= led_in;
         dur_ff  <= dur_in;
         last_ff <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff  <= 1'b0;
         valid_ff <= 1'b0;
         idx_ff   <= '0;
         phase_ff <= PH_ON;
      end else begin
         busy_ff  <= busy_in;
         valid_ff <= valid_in;
         idx_ff   <= idx_in;
         phase_ff <= phase_in;
      end
   end

endmodule

FILE: design/mcpe_checker.sv
// port checker of the morse pulse encoder and its bind
`include "morse_character_pulse_encoder_core_macros.svh"

module mcpe_checker (
   input logic clock,
   input logic reset,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_led_on,
   input logic rsp_last
);

   `MCPE_ASSERT(a_rsp_hold, rsp_valid && !rsp_ready |=> rsp_valid, "rsp valid dropped while stalled")
   `MCPE_ASSERT(a_on_not_last, rsp_valid && rsp_led_on |-> !rsp_last, "led on interval marked last")
   `MCPE_ASSERT_RST(a_rsp_idle_after_reset, reset |=> !rsp_valid, "rsp valid after reset")
   `MCPE_ASSERT_RST(a_req_ready_after_reset, reset |=> req_ready, "req not ready after reset")

endmodule

bind morse_character_pulse_encoder_core mcpe_checker u_mcpe_checker (
   .clock      (clock),
   .reset      (reset),
   .req_ready  (req_port.ready),
   .rsp_valid  (rsp_port.valid),
   .rsp_ready  (rsp_port.ready),
   .rsp_led_on (rsp_port.led_on),
   .rsp_last   (rsp_port.last)
);

FILE: bench/morse_character_pulse_encoder_core_test.sv
// self-checking testbench for the morse character pulse encoder core
module morse_character_pulse_encoder_core_test;
   timeunit 1ns;
   timeprecision 1ps;

   typedef logic [mcpe_pkg::CHAR_W-1:0] char_type;
   typedef logic [mcpe_pkg::UNIT_W-1:0] unit_type;
   typedef logic [mcpe_pkg::DUR_W-1:0]  dur_type;

   localparam int CYCLE_LIMIT = 1000000;
   localparam int PHASES      = 6;
   localparam int PER_PHASE   = 50;

   localparam char_type OPENING [24] = '{
      8'h00, "E", "E", "e", " ", " ", "0", "9", "A", "Z", "a", "z",
      "Q", "5", 8'h2F, 8'h3A, 8'h40, 8'h5B, 8'h60, 8'h7B, 8'hFF, 8'h80, "7", "Y"
   };

   typedef struct packed {
      logic    led_on;
      dur_type duration_ticks;
      logic    last;
   } morse_interval_type;

   class interval_tracker;
      string digit_morse [10] = '{
         "-----", ".----", "..---", "...--", "....-",
         ".....", "-....", "--...", "---..", "----."
      };
      string letter_morse [26] = '{
         ".-", "-...", "-.-.", "-..", ".", "..-.", "--.", "....", "..", ".---",
         "-.-", ".-..", "--", "-.", "---", ".--.", "--.-", ".-.", "...", "-",
         "..-", "...-", ".--", "-..-", "-.--", "--.."
      };
      morse_interval_type due_intervals [$];
      unit_type           unit_len;
      char_type           prev_char;
      int                 failures;

      function new();
         unit_len  = mcpe_pkg::UNIT_RESET;
         prev_char = '0;
         failures  = 0;
      endfunction

      function void set_unit(input unit_type u);
         unit_len = u;
      endfunction

      function int pending();
         return due_intervals.size();
      endfunction

      function void add_interval(input logic on, input int units);
         morse_interval_type iv;
         iv.led_on         = on;
         iv.duration_ticks = dur_type'(unit_len * units);
         iv.last           = 1'b0;
         due_intervals.push_back(iv);
      endfunction

      // returns how many intervals the character is to produce
      function int take_char(input char_type code);
         char_type c;
         string    elems;
         int       start;
         c     = code;
         elems = "";
         start = due_intervals.size();
         if (c >= mcpe_pkg::ASCII_LOWER_A && c <= mcpe_pkg::ASCII_LOWER_Z) begin
            c = c - mcpe_pkg::CASE_OFFSET;
         end
         if (c >= mcpe_pkg::ASCII_ZERO && c <= mcpe_pkg::ASCII_NINE) begin
            elems = digit_morse[c - mcpe_pkg::ASCII_ZERO];
         end else if (c >= mcpe_pkg::ASCII_UPPER_A && c <= mcpe_pkg::ASCII_UPPER_Z) begin
            elems = letter_morse[c - mcpe_pkg::ASCII_UPPER_A];
         end else if (c != mcpe_pkg::ASCII_SPACE) begin
            return 0;
         end
         if (c == mcpe_pkg::ASCII_SPACE) begin
            add_interval(1'b0, 6);
         end else begin
            for (int i = 0; i < elems.len(); i++) begin
               add_interval(1'b1, (elems[i] == "-") ? 3 : 1);
               add_interval(1'b0, 1);
            end
         end
         if (prev_char != c) begin
            add_interval(1'b0, 2);
         end
         prev_char = c;
         due_intervals[due_intervals.size()-1].last = 1'b1;
         return due_intervals.size() - start;
      endfunction

      function void match_interval(input logic on, input dur_type dur,
                                   input logic lst);
         morse_interval_type want;
         if (due_intervals.size() == 0) begin
            $error("unexpected rsp transfer: led_on %0d duration_ticks %0d last %0d",
                   on, dur, lst);
            failures++;
            return;
         end
         want = due_intervals.pop_front();
         if (on !== want.led_on) begin
            $error("led_on: expected %0d, got %0d", want.led_on, on);
            failures++;
         end
         if (dur !== want.duration_ticks) begin
            $error("duration_ticks: expected %0d, got %0d", want.duration_ticks, dur);
            failures++;
         end
         if (lst !== want.last) begin
            $error("last: expected %0d, got %0d", want.last, lst);
            failures++;
         end
      endfunction
   endclass

   logic clock;
   logic reset;
   bit   quiet;
   int   cycles;
   int   hold_left;

   interval_tracker tracker;

   mcpe_req_if req_ch ();
   mcpe_rsp_if rsp_ch ();
   mcpe_csr_if csr_ch ();

   morse_character_pulse_encoder_core u_top (
      .clock    (clock),
      .reset    (reset),
      .req_port (req_ch),
      .rsp_port (rsp_ch),
      .csr_port (csr_ch)
   );

   always begin
      clock = 1'b1;
      #5;
      clock = 1'b0;
      #5;
   end

   function automatic int pick_gap();
      int r;
      r = $urandom_range(0, 99);
      if (quiet || r < 50) begin
         return 0;
      end else if (r < 90) begin
         return $urandom_range(1, 3);
      end
      return $urandom_range(8, 40);
   endfunction

   // result side: random back-pressure
   always @(posedge clock) begin
      if (hold_left > 0) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= hold_left - 1;
      end else if (!quiet && $urandom_range(0, 99) < 25) begin
         rsp_ch.ready <= 1'b0;
         hold_left    <= pick_gap();
      end else begin
         rsp_ch.ready <= 1'b1;
      end
   end

   always @(posedge clock) begin
      if (!reset && rsp_ch.valid && rsp_ch.ready) begin
         tracker.match_interval(rsp_ch.led_on, rsp_ch.duration_ticks, rsp_ch.last);
      end
   end

   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles >= CYCLE_LIMIT) begin
         $display("CHECKS FAILED");
         $finish;
      end
   end

   task automatic send_char(input char_type c, output int produced);
      int gap;
      gap = pick_gap();
      if (gap > 0) begin
         req_ch.valid <= 1'b0;
         repeat (gap) @(posedge clock);
      end
      req_ch.valid     <= 1'b1;
      req_ch.char_code <= c;
      @(posedge clock);
      while (!req_ch.ready) @(posedge clock);
      produced = tracker.take_char(c);
   endtask

   task automatic drain();
      req_ch.valid <= 1'b0;
      while (tracker.pending() != 0) @(posedge clock);
      repeat (8) @(posedge clock);
   endtask

   task automatic write_unit(input unit_type u);
      csr_ch.valid      <= 1'b1;
      csr_ch.unit_ticks <= u;
      @(posedge clock);
      while (!csr_ch.ready) @(posedge clock);
      tracker.set_unit(u);
      csr_ch.valid <= 1'b0;
   endtask

   task automatic send_random(input int wanted);
      char_type c;
      char_type last_sent;
      int       r;
      int       sent;
      int       produced;
      last_sent = "A";
      sent      = 0;
      while (sent < wanted) begin
         r = $urandom_range(0, 99);
         if (r < 15) begin
            c = last_sent;
            if ($urandom_range(0, 1) && c >= mcpe_pkg::ASCII_UPPER_A &&
                c <= mcpe_pkg::ASCII_UPPER_Z) begin
               c = c + mcpe_pkg::CASE_OFFSET;
            end
         end else if (r < 25) begin
            c = char_type'($urandom_range(0, 255));
         end else if (r < 30) begin
            c = mcpe_pkg::ASCII_SPACE;
         end else if (r < 45) begin
            c = mcpe_pkg::ASCII_ZERO + char_type'($urandom_range(0, 9));
         end else begin
            c = mcpe_pkg::ASCII_UPPER_A + char_type'($urandom_range(0, 25));
            if ($urandom_range(0, 1)) begin
               c = c + mcpe_pkg::CASE_OFFSET;
            end
         end
         send_char(c, produced);
         if (produced > 0) begin
            sent++;
            last_sent = (c >= mcpe_pkg::ASCII_LOWER_A && c <= mcpe_pkg::ASCII_LOWER_Z) ?
                        c - mcpe_pkg::CASE_OFFSET : c;
         end
      end
   endtask

   initial begin
      unit_type unit_plan [PHASES];
      int       produced;
      tracker           = new();
      reset             = 1'b1;
      quiet             = 1'b0;
      cycles            = 0;
      hold_left         = 0;
      req_ch.valid      = 1'b0;
      req_ch.char_code  = '0;
      rsp_ch.ready      = 1'b0;
      csr_ch.valid      = 1'b0;
      csr_ch.unit_ticks = '0;
      unit_plan[0] = 20'd1;
      unit_plan[1] = 20'hFFFFF;
      unit_plan[2] = 20'd0;
      unit_plan[3] = 20'd1000000;
      unit_plan[4] = unit_type'($urandom_range(1, 1000000));
      unit_plan[5] = 20'd3;

      repeat (4) @(posedge clock);
      reset <= 1'b0;

      // reset unit length first, with repeats, range bounds and characters that have no code
      foreach (OPENING[i]) begin
         send_char(OPENING[i], produced);
      end

      for (int p = 0; p < PHASES; p++) begin
         drain();
         write_unit(unit_plan[p]);
         quiet = (p == 0);
         send_random(PER_PHASE);
      end

      drain();
      repeat (10) @(posedge clock);
      if (tracker.failures == 0 && tracker.pending() == 0) begin
         $display("ALL CHECKS PASSED");
      end else begin
         $display("CHECKS FAILED");
      end
      $finish;
   end

endmodule
